// ----- hdl/cbm_pkg.sv -----
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int AddrWidth    = 16;
    localparam int DataWidth    = 8;
    localparam int CmdWidth     = 3;
    localparam int MapWidth     = 22;
    localparam int PrgBankWidth = 9;   // 8 KB banks, wraps modulo 512
    localparam int ChrBankWidth = 8;   // 1 KB banks
    localparam int PrgOffWidth  = 13;  // offset inside an 8 KB window
    localparam int ChrOffWidth  = 10;  // offset inside a 1 KB window
    localparam int NumBankRegs  = 8;
    localparam int NumPrgWin    = 4;
    localparam int NumChrWin    = 8;

    localparam logic [DataWidth-1:0] PrgBanksReset = 8'd2;

    typedef enum logic [CmdWidth-1:0] {
        CMD_CPU_READ  = 3'd0,
        CMD_CPU_WRITE = 3'd1,
        CMD_PPU_READ  = 3'd2,
        CMD_TICK      = 3'd3,
        CMD_IRQ_ACK   = 3'd4
    } cmd_t;

    // CPU write decode, addr[14:13] inside 0x8000-0xFFFF
    typedef enum logic [1:0] {
        RGN_BANK   = 2'd0,
        RGN_MIRROR = 2'd1,
        RGN_IRQCNT = 2'd2,
        RGN_IRQEN  = 2'd3
    } region_t;

    typedef struct packed {
        logic                hit;
        logic [MapWidth-1:0] rom_offset;
        logic                irq_pending;
        logic                mirror_horizontal;
    } result_t;

endpackage

// ----- hdl/cbm_core.sv -----
`timescale 1ns / 1ps

module cbm_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cbm_pkg::DataWidth-1:0]       cfg_wr_data,
    input  logic                                fire,
    input  logic [cbm_pkg::CmdWidth-1:0]        cmd,
    input  logic [cbm_pkg::AddrWidth-1:0]       addr,
    input  logic [cbm_pkg::DataWidth-1:0]       data,
    output cbm_pkg::result_t                    result
);
    import cbm_pkg::*;

    logic [DataWidth-1:0]    prg_banks_reg;
    logic [2:0]              target_reg,       target_next;
    logic                    prg_swap_reg,     prg_swap_next;
    logic                    chr_invert_reg,   chr_invert_next;
    logic [DataWidth-1:0]    bank_reg   [NumBankRegs];
    logic [DataWidth-1:0]    bank_next  [NumBankRegs];
    logic [ChrBankWidth-1:0] chr_reg    [NumChrWin];
    logic [ChrBankWidth-1:0] chr_next   [NumChrWin];
    logic [PrgBankWidth-1:0] prg_reg    [NumPrgWin];
    logic [PrgBankWidth-1:0] prg_next   [NumPrgWin];
    logic [DataWidth-1:0]    reload_val_reg,   reload_val_next;
    logic [DataWidth-1:0]    count_reg,        count_next;
    logic                    irq_en_reg,       irq_en_next;
    logic                    irq_raised_reg,   irq_raised_next;
    logic                    reload_req_reg,   reload_req_next;
    logic                    mirror_reg,       mirror_next;

    cmd_t                    cmd_code;
    region_t                 region;
    logic                    odd;
    logic [PrgBankWidth-1:0] n8;
    logic [PrgBankWidth-1:0] fix_lo;
    logic [PrgBankWidth-1:0] fix_hi;
    logic [PrgBankWidth-1:0] sel6;
    logic [PrgBankWidth-1:0] sel7;
    logic [ChrBankWidth-1:0] pair_grp [4];
    logic [ChrBankWidth-1:0] one_grp  [4];
    logic [1:0]              prg_idx;
    logic [2:0]              chr_idx;

    assign cmd_code = cmd_t'(cmd);
    assign region   = region_t'(addr[14:13]);
    assign odd      = addr[0];
    assign prg_idx  = addr[14:13];
    assign chr_idx  = addr[12:10];

    // bank registers as they stand after a bank load
    always_comb
    begin
        for (int i = 0; i < NumBankRegs; i++)
        begin
            bank_next[i] = bank_reg[i];
        end
        if (fire && cmd_code == CMD_CPU_WRITE && addr[15] && region == RGN_BANK && odd)
        begin
            bank_next[target_reg] = data;
        end
    end

    // window maps computed from the post-load bank registers
    always_comb
    begin
        n8     = {prg_banks_reg, 1'b0};
        fix_lo = n8 - PrgBankWidth'(2);
        fix_hi = n8 - PrgBankWidth'(1);
        sel6   = {3'b000, bank_next[6][5:0]};
        sel7   = {3'b000, bank_next[7][5:0]};
        pair_grp[0] = {bank_next[0][7:1], 1'b0};
        pair_grp[1] = {bank_next[0][7:1], 1'b1};
        pair_grp[2] = {bank_next[1][7:1], 1'b0};
        pair_grp[3] = {bank_next[1][7:1], 1'b1};
        for (int k = 0; k < 4; k++)
        begin
            one_grp[k] = bank_next[2 + k];
        end
    end

    always_comb
    begin
        target_next     = target_reg;
        prg_swap_next   = prg_swap_reg;
        chr_invert_next = chr_invert_reg;
        chr_next        = chr_reg;
        prg_next        = prg_reg;
        reload_val_next = reload_val_reg;
        count_next      = count_reg;
        irq_en_next     = irq_en_reg;
        irq_raised_next = irq_raised_reg;
        reload_req_next = reload_req_reg;
        mirror_next     = mirror_reg;
        result          = '0;

        if (fire)
        begin
            case (cmd_code)
                CMD_CPU_READ:
                begin
                    if (addr[15])
                    begin
                        result.hit        = 1'b1;
                        result.rom_offset = {prg_reg[prg_idx], addr[PrgOffWidth-1:0]};
                    end
                end
                CMD_CPU_WRITE:
                begin
                    if (addr[15])
                    begin
                        case (region)
                            RGN_BANK:
                            begin
                                if (!odd)
                                begin
                                    target_next     = data[2:0];
                                    prg_swap_next   = data[6];
                                    chr_invert_next = data[7];
                                end
                                else
                                begin
                                    for (int k = 0; k < 4; k++)
                                    begin
                                        if (chr_invert_reg)
                                        begin
                                            chr_next[k]     = one_grp[k];
                                            chr_next[4 + k] = pair_grp[k];
                                        end
                                        else
                                        begin
                                            chr_next[k]     = pair_grp[k];
                                            chr_next[4 + k] = one_grp[k];
                                        end
                                    end
                                    prg_next[0] = prg_swap_reg ? fix_lo : sel6;
                                    prg_next[1] = sel7;
                                    prg_next[2] = prg_swap_reg ? sel6 : fix_lo;
                                    prg_next[3] = fix_hi;
                                end
                            end
                            RGN_MIRROR:
                            begin
                                if (!odd)
                                begin
                                    mirror_next = data[0];
                                end
                            end
                            RGN_IRQCNT:
                            begin
                                if (!odd)
                                begin
                                    reload_val_next = data;
                                end
                                else
                                begin
                                    reload_req_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (!odd)
                                begin
                                    irq_en_next     = 1'b0;
                                    irq_raised_next = 1'b0;
                                end
                                else
                                begin
                                    irq_en_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                CMD_PPU_READ:
                begin
                    if (addr[15:13] == 3'b000)
                    begin
                        result.hit        = 1'b1;
                        result.rom_offset = {4'b0000, chr_reg[chr_idx],
                                             addr[ChrOffWidth-1:0]};
                    end
                end
                CMD_TICK:
                begin
                    if (count_reg == '0 || reload_req_reg)
                    begin
                        count_next      = reload_val_reg;
                        reload_req_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg - DataWidth'(1);
                    end
                    if (count_next == '0 && irq_en_reg)
                    begin
                        irq_raised_next = 1'b1;
                    end
                end
                CMD_IRQ_ACK:
                begin
                    irq_raised_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        result.irq_pending       = irq_raised_next;
        result.mirror_horizontal = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg  <= PrgBanksReset;
            target_reg     <= '0;
            prg_swap_reg   <= 1'b0;
            chr_invert_reg <= 1'b0;
            for (int i = 0; i < NumBankRegs; i++)
            begin
                bank_reg[i] <= '0;
            end
            for (int i = 0; i < NumChrWin; i++)
            begin
                chr_reg[i] <= '0;
            end
            // 8 KB banks 0, 1, second-last, last of the reset bank count
            prg_reg[0]     <= PrgBankWidth'(0);
            prg_reg[1]     <= PrgBankWidth'(1);
            prg_reg[2]     <= {PrgBanksReset, 1'b0} - PrgBankWidth'(2);
            prg_reg[3]     <= {PrgBanksReset, 1'b0} - PrgBankWidth'(1);
            reload_val_reg <= '0;
            count_reg      <= '0;
            irq_en_reg     <= 1'b0;
            irq_raised_reg <= 1'b0;
            reload_req_reg <= 1'b0;
            mirror_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prg_banks_reg <= cfg_wr_data;
            end
            target_reg     <= target_next;
            prg_swap_reg   <= prg_swap_next;
            chr_invert_reg <= chr_invert_next;
            bank_reg       <= bank_next;
            chr_reg        <= chr_next;
            prg_reg        <= prg_next;
            reload_val_reg <= reload_val_next;
            count_reg      <= count_next;
            irq_en_reg     <= irq_en_next;
            irq_raised_reg <= irq_raised_next;
            reload_req_reg <= reload_req_next;
            mirror_reg     <= mirror_next;
        end
    end

    // interrupt only goes up on a scanline tick with the interrupt enabled
    a_irq_rise_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_raised_reg) |-> $past(fire && cmd_code == CMD_TICK && irq_en_reg))
        else $error("irq raised outside an enabled tick");

    // counter moves only on ticks
    a_count_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && cmd_code == CMD_TICK) |=> $stable(count_reg))
        else $error("irq counter changed without a tick");

    // acknowledge always drops the line
    a_ack_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd_code == CMD_IRQ_ACK |=> !irq_raised_reg)
        else $error("irq still raised after acknowledge");

endmodule

// ----- hdl/cbm_out_buf.sv -----
`timescale 1ns / 1ps

module cbm_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cbm_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output cbm_pkg::result_t out_data
);
    import cbm_pkg::*;

    logic    valid_reg, valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        valid_next      = valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                valid_next      = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next  = push_data;
                valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> valid_reg)
        else $error("skid holds an item while the output is empty");

    a_push_into_skid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall && push |=> skid_valid_reg)
        else $error("item pushed behind a stalled output was lost");

    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid item dropped while output stalled");

endmodule

// ----- hdl/cartridge_bank_mapper_scanline_irq.sv -----
`timescale 1ns / 1ps

// Cartridge bank switcher with scanline interrupt counter. Each input item is
// one command (cpu read, cpu write, ppu read, scanline tick, irq acknowledge)
// and yields exactly one result item: hit and rom_offset for reads that land
// in program ROM (cpu 0x8000-0xFFFF, four 8 KB windows) or pattern ROM (ppu
// below 0x2000, eight 1 KB windows), plus the irq line and mirroring after the
// command. Rate: one item per clock while in_stall is low. All decode, window
// lookup, remap and counter update sit in one layer of logic between the input
// port and the result register. A two-entry output buffer (result register
// plus skid) lets the input keep accepting while a result waits; in_stall
// comes straight from a flop. The user must write prg_banks_16k (reset 2) by
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this. It
// takes effect at the next bank-register load, not on the current windows.
module cartridge_bank_mapper_scanline_irq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cbm_pkg::DataWidth-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cbm_pkg::CmdWidth-1:0]  cmd,
    input  logic [cbm_pkg::AddrWidth-1:0] addr,
    input  logic [cbm_pkg::DataWidth-1:0] data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [cbm_pkg::MapWidth-1:0]  rom_offset,
    output logic                          irq_pending,
    output logic                          mirror_horizontal
);
    import cbm_pkg::*;

    logic    fire;
    logic    buf_full;
    result_t core_result;
    result_t out_data;

    // item accepted whenever the skid slot is free
    assign in_stall = buf_full;
    assign fire     = in_valid && !buf_full;

    cbm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .cmd         (cmd),
        .addr        (addr),
        .data        (data),
        .result      (core_result)
    );

    cbm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign hit               = out_data.hit;
    assign rom_offset        = out_data.rom_offset;
    assign irq_pending       = out_data.irq_pending;
    assign mirror_horizontal = out_data.mirror_horizontal;

endmodule
